[rtl/dssm_pkg.sv]
// Shared types, command codes and reset tables of the drum step sequencer.
package dssm_pkg;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_KEY   = 3'd1,
        CMD_SEL   = 3'd2,
        CMD_CLR   = 3'd3,
        CMD_INST  = 3'd4,
        CMD_START = 3'd5,
        CMD_STOP  = 3'd6,
        CMD_NOP   = 3'd7
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_B1,
        S_B2,
        S_WEND,
        S_CLR,
        S_SEL,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        A_NONE,
        A_ADV,
        A_CLR,
        A_STOP
    } t_after;

    typedef enum logic [1:0] {
        CFG_STEP_TICKS  = 2'd0,
        CFG_FLASH_TICKS = 2'd1,
        CFG_CHANNEL     = 2'd2,
        CFG_VELOCITY    = 2'd3
    } t_cfg_idx;

    localparam logic [3:0]  ST_NOTE_ON    = 4'h9;
    localparam logic [3:0]  ST_NOTE_OFF   = 4'h8;
    localparam logic [15:0] RST_STEP_TICKS  = 16'd40;
    localparam logic [15:0] RST_FLASH_TICKS = 16'd10;
    localparam logic [3:0]  RST_CHANNEL     = 4'd0;
    localparam logic [6:0]  RST_VELOCITY    = 7'd127;
    localparam int          LED_BITS        = 16;

    typedef struct packed {
        logic [3:0]  step;
        logic [2:0]  trk;
        logic [15:0] led;
        logic        run;
    } t_snap;

    typedef struct packed {
        logic [7:0] midi_byte;
        logic       valid;
        logic       last;
        t_snap      snap;
    } t_result;

    function automatic logic [63:0] rst_pattern(input logic [3:0] t);
        logic [63:0] v;
        case (t)
            4'd0:    v = 64'hFFFF;
            4'd1:    v = 64'h1111;
            4'd2:    v = 64'h4444;
            4'd3:    v = 64'h4444;
            default: v = 64'h0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] rst_note(input logic [3:0] t);
        logic [7:0] v;
        case (t)
            4'd0:    v = 8'd42;
            4'd1:    v = 8'd36;
            4'd2:    v = 8'd50;
            4'd3:    v = 8'd38;
            default: v = 8'd40 + 8'(t);
        endcase
        return v;
    endfunction

endpackage

[rtl/drum_step_sequencer_midi_top.sv]
// Drum step sequencer: pattern and note memories, track walker and MIDI word output.
//
// An item is taken when i_start is high and o_busy is low. Key, select, set-instrument and
// no-op commands, and a tick that does not end a step, send no notes. A command that sends
// notes walks the tracks through the one read port of the pattern and note memories, a
// note message per hit; a step boundary sends note-offs, then note-ons. Clear all sends
// note-offs first when running, then sweeps the pattern memory track by track. Results
// come out one word per cycle at most, each shown for exactly one cycle with o_strobe;
// the receiver cannot hold them off. The final word of an item has o_last set and o_busy
// is low from that cycle on.
module drum_step_sequencer_midi_top #(
    parameter int STEPS  = 16,
    parameter int TRACKS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [2:0]  i_cmd,
    input  logic [3:0]  i_key_index,
    input  logic [2:0]  i_track_select,
    input  logic [7:0]  i_instrument_value,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        o_busy,
    output logic        o_strobe,
    output logic [7:0]  o_midi_byte,
    output logic        o_byte_valid,
    output logic        o_last,
    output logic [3:0]  o_step_index,
    output logic [2:0]  o_shown_track,
    output logic [15:0] o_led_mask,
    output logic        o_running
);
    import dssm_pkg::*;

    localparam int SW = $clog2(STEPS);
    localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;

    function automatic logic [TW-1:0] sel_mod(input logic [2:0] s);
        logic [2:0] v;
        v = s;
        for (int i = 0; i < 8; i++) begin
            if (32'(v) >= TRACKS) begin
                v = 3'(32'(v) - TRACKS);
            end
        end
        return TW'(v);
    endfunction

    // memories
    logic [STEPS-1:0] r_pat_mem [TRACKS];
    logic [7:0]       r_ins_mem [TRACKS];
    logic [STEPS-1:0] r_pat_q;
    logic [7:0]       r_ins_q;
    logic [TW-1:0]    r_rd_addr;
    logic [TRACKS-1:0] r_pat_vld, r_ins_vld;

    logic             pat_we, ins_we;
    logic [TW-1:0]    pat_wa, ins_wa, rd_addr;
    logic [STEPS-1:0] pat_wd;
    logic [7:0]       ins_wd;
    logic [STEPS-1:0] pat_eff;
    logic [7:0]       ins_eff;

    // control and state
    t_state           r_state, n_state;
    t_after           r_after, n_after;
    logic             r_on, n_on;
    logic [TW-1:0]    r_trk, n_trk;
    logic [TW-1:0]    r_disp, n_disp;
    logic [SW-1:0]    r_step, n_step;
    logic [15:0]      r_tick, n_tick;
    logic             r_play, n_play;
    logic [STEPS-1:0] r_shown, n_shown;
    logic [7:0]       r_note, n_note;

    logic [15:0]      r_step_ticks, r_flash_ticks;
    logic [3:0]       r_channel;
    logic [6:0]       r_velocity;

    logic             r_strobe;
    t_result          r_out;
    logic             r_have_pend;
    t_result          r_pend;

    logic             push_en, fin;
    logic [7:0]       push_byte;
    t_snap            snap_now;
    logic [15:0]      eff_step, flash_len;
    logic [16:0]      tick_sum;
    logic             tick_wrap, flash_on, key_ok, last_trk, hit;
    logic [STEPS-1:0] key_bit;
    logic [TW-1:0]    sel_val;

    assign pat_eff  = r_pat_vld[r_rd_addr] ? r_pat_q : STEPS'(rst_pattern(4'(r_rd_addr)));
    assign ins_eff  = r_ins_vld[r_rd_addr] ? r_ins_q : rst_note(4'(r_rd_addr));
    assign eff_step = (r_step_ticks == 16'd0) ? 16'd1 : r_step_ticks;
    assign flash_len = (r_flash_ticks < eff_step) ? r_flash_ticks : eff_step;
    assign tick_sum = 17'(r_tick) + 17'd1;
    assign tick_wrap = (tick_sum >= 17'(eff_step));
    assign flash_on = r_play && (r_tick < flash_len) && (32'(r_step) < LED_BITS);
    assign key_ok   = (32'(i_key_index) < STEPS);
    assign key_bit  = STEPS'(1) << i_key_index;
    assign last_trk = (r_trk == TW'(TRACKS - 1));
    assign hit      = pat_eff[r_step] && !ins_eff[7];
    assign sel_val  = sel_mod(i_track_select);

    always_comb begin
        snap_now.step = 4'(r_step);
        snap_now.trk  = 3'(r_disp);
        snap_now.led  = 16'(r_shown) ^ (flash_on ? (16'(1) << r_step) : 16'h0);
        snap_now.run  = r_play;
    end

    always_ff @(posedge i_clk) begin
        if (pat_we) begin
            r_pat_mem[pat_wa] <= pat_wd;
        end
        if (ins_we) begin
            r_ins_mem[ins_wa] <= ins_wd;
        end
        r_pat_q   <= r_pat_mem[rd_addr];
        r_ins_q   <= r_ins_mem[rd_addr];
        r_rd_addr <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_vld <= '0;
            r_ins_vld <= '0;
        end else begin
            if (pat_we) begin
                r_pat_vld[pat_wa] <= 1'b1;
            end
            if (ins_we) begin
                r_ins_vld[ins_wa] <= 1'b1;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_after   = r_after;
        n_on      = r_on;
        n_trk     = r_trk;
        n_disp    = r_disp;
        n_step    = r_step;
        n_tick    = r_tick;
        n_play    = r_play;
        n_shown   = r_shown;
        n_note    = r_note;
        push_en   = 1'b0;
        push_byte = 8'h0;
        fin       = 1'b0;
        pat_we    = 1'b0;
        pat_wa    = r_disp;
        pat_wd    = r_shown;
        ins_we    = 1'b0;
        ins_wa    = r_disp;
        ins_wd    = i_instrument_value;
        rd_addr   = r_trk;
        unique case (r_state)
            S_IDLE: begin
                rd_addr = sel_val;
                if (i_start) begin
                    n_state = S_FIN;
                    unique case (t_cmd'(i_cmd))
                        CMD_TICK: begin
                            if (r_play) begin
                                n_tick = tick_sum[15:0];
                                if (tick_wrap) begin
                                    n_on    = 1'b0;
                                    n_after = A_ADV;
                                    n_trk   = '0;
                                    n_state = S_RD;
                                end
                            end
                        end
                        CMD_KEY: begin
                            if (key_ok) begin
                                n_shown = r_shown ^ key_bit;
                                pat_we  = 1'b1;
                                pat_wd  = r_shown ^ key_bit;
                            end
                        end
                        CMD_SEL: begin
                            n_disp  = sel_val;
                            n_state = S_SEL;
                        end
                        CMD_CLR: begin
                            n_trk = '0;
                            if (r_play) begin
                                n_on    = 1'b0;
                                n_after = A_CLR;
                                n_state = S_RD;
                            end else begin
                                n_state = S_CLR;
                            end
                        end
                        CMD_INST: begin
                            ins_we = 1'b1;
                        end
                        CMD_START: begin
                            if (!r_play) begin
                                n_play  = 1'b1;
                                n_step  = '0;
                                n_tick  = '0;
                                n_on    = 1'b1;
                                n_after = A_NONE;
                                n_trk   = '0;
                                n_state = S_RD;
                            end
                        end
                        CMD_STOP: begin
                            if (r_play) begin
                                n_on    = 1'b0;
                                n_after = A_STOP;
                                n_trk   = '0;
                                n_state = S_RD;
                            end
                        end
                        CMD_NOP: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (hit) begin
                    push_en   = 1'b1;
                    push_byte = {(r_on ? ST_NOTE_ON : ST_NOTE_OFF), r_channel};
                    n_note    = ins_eff;
                    n_state   = S_B1;
                end else if (last_trk) begin
                    n_state = S_WEND;
                end else begin
                    n_trk   = r_trk + 1'b1;
                    n_state = S_RD;
                end
            end
            S_B1: begin
                push_en   = 1'b1;
                push_byte = r_note;
                n_state   = S_B2;
            end
            S_B2: begin
                push_en   = 1'b1;
                push_byte = {1'b0, r_velocity};
                if (last_trk) begin
                    n_state = S_WEND;
                end else begin
                    n_trk   = r_trk + 1'b1;
                    n_state = S_RD;
                end
            end
            S_WEND: begin
                n_after = A_NONE;
                unique case (r_after)
                    A_ADV: begin
                        n_step  = (r_step == SW'(STEPS - 1)) ? '0 : r_step + 1'b1;
                        n_tick  = '0;
                        n_on    = 1'b1;
                        n_trk   = '0;
                        n_state = S_RD;
                    end
                    A_CLR: begin
                        n_trk   = '0;
                        n_state = S_CLR;
                    end
                    A_STOP: begin
                        n_play  = 1'b0;
                        n_state = S_FIN;
                    end
                    A_NONE: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_CLR: begin
                pat_we = 1'b1;
                pat_wa = r_trk;
                pat_wd = '0;
                if (last_trk) begin
                    n_disp  = '0;
                    n_step  = '0;
                    n_tick  = '0;
                    n_shown = '0;
                    n_state = S_FIN;
                end else begin
                    n_trk = r_trk + 1'b1;
                end
            end
            S_SEL: begin
                n_shown = pat_eff;
                n_state = S_FIN;
            end
            S_FIN: begin
                fin     = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_after       <= A_NONE;
            r_on          <= 1'b0;
            r_trk         <= '0;
            r_disp        <= TW'(1 % TRACKS);
            r_step        <= '0;
            r_tick        <= '0;
            r_play        <= 1'b0;
            r_shown       <= STEPS'(rst_pattern(4'(1 % TRACKS)));
            r_step_ticks  <= RST_STEP_TICKS;
            r_flash_ticks <= RST_FLASH_TICKS;
            r_channel     <= RST_CHANNEL;
            r_velocity    <= RST_VELOCITY;
            r_strobe      <= 1'b0;
            r_have_pend   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_on    <= n_on;
            r_trk   <= n_trk;
            r_disp  <= n_disp;
            r_step  <= n_step;
            r_tick  <= n_tick;
            r_play  <= n_play;
            r_shown <= n_shown;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_STEP_TICKS:  r_step_ticks  <= i_cfg_data;
                    CFG_FLASH_TICKS: r_flash_ticks <= i_cfg_data;
                    CFG_CHANNEL:     r_channel     <= i_cfg_data[3:0];
                    CFG_VELOCITY:    r_velocity    <= i_cfg_data[6:0];
                endcase
            end
            // one word held back so the last one of an item can be marked
            r_strobe <= push_en ? r_have_pend : fin;
            if (push_en) begin
                r_have_pend <= 1'b1;
            end else if (fin) begin
                r_have_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_note <= n_note;
        if (push_en) begin
            r_out            <= {r_pend.midi_byte, r_pend.valid, 1'b0, r_pend.snap};
            r_pend.midi_byte <= push_byte;
            r_pend.valid     <= 1'b1;
            r_pend.last      <= 1'b0;
            r_pend.snap      <= snap_now;
        end else if (fin) begin
            if (r_have_pend) begin
                r_out <= {r_pend.midi_byte, r_pend.valid, 1'b1, r_pend.snap};
            end else begin
                r_out <= {8'h0, 1'b0, 1'b1, snap_now};
            end
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_midi_byte   = r_out.midi_byte;
    assign o_byte_valid  = r_out.valid;
    assign o_last        = r_out.last;
    assign o_step_index  = r_out.snap.step;
    assign o_shown_track = r_out.snap.trk;
    assign o_led_mask    = r_out.snap.led;
    assign o_running     = r_out.snap.run;

endmodule

[rtl/dssm_chk.sv]
// Port-level checks of the drum step sequencer, bound to the top level.
module dssm_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_strobe,
    input logic       o_last,
    input logic       o_byte_valid,
    input logic [7:0] o_midi_byte
);

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted command did not raise busy");

    a_mid_word_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> o_busy)
        else $error("non-final word while idle");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !o_busy)
        else $error("final word while still busy");

    a_done_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> (o_strobe && o_last))
        else $error("command ended without a final word");

    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_byte_valid) |-> (o_last && o_midi_byte == 8'h0))
        else $error("status word not final or not zero");

endmodule

bind drum_step_sequencer_midi_top dssm_chk u_dssm_chk (.*);

[bench/tb_top.sv]
// Self-checking bench for the drum step sequencer: directed and random command words.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dssm_pkg::*;

    localparam int TRACK_COUNT = 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 100;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic [2:0]  i_cmd;
    logic [3:0]  i_key_index;
    logic [2:0]  i_track_select;
    logic [7:0]  i_instrument_value;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        o_busy;
    logic        o_strobe;
    logic [7:0]  o_midi_byte;
    logic        o_byte_valid;
    logic        o_last;
    logic [3:0]  o_step_index;
    logic [2:0]  o_shown_track;
    logic [15:0] o_led_mask;
    logic        o_running;

    drum_step_sequencer_midi_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .i_cmd              (i_cmd),
        .i_key_index        (i_key_index),
        .i_track_select     (i_track_select),
        .i_instrument_value (i_instrument_value),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .o_busy             (o_busy),
        .o_strobe           (o_strobe),
        .o_midi_byte        (o_midi_byte),
        .o_byte_valid       (o_byte_valid),
        .o_last             (o_last),
        .o_step_index       (o_step_index),
        .o_shown_track      (o_shown_track),
        .o_led_mask         (o_led_mask),
        .o_running          (o_running)
    );

    // mirror of the sequencer
    logic [15:0] pattern   [TRACK_COUNT];
    logic [7:0]  note_num  [TRACK_COUNT];
    logic [3:0]  cur_step;
    int unsigned tick_cnt;
    logic [2:0]  shown;
    logic        playing;
    logic [15:0] reg_step_ticks;
    logic [15:0] reg_flash_ticks;
    logic [3:0]  reg_channel;
    logic [6:0]  reg_velocity;

    t_result     words_due[$];
    t_result     held_word;
    logic        have_held;
    t_result     want_word;

    int errors;
    int items_sent;
    int words_checked;
    int notes_checked;
    int cycles;
    bit gaps_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic note_error(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic void reset_mirror();
        for (int t = 0; t < TRACK_COUNT; t++) begin
            pattern[t]  = 16'h0000;
            note_num[t] = 8'(40 + t);
        end
        pattern[0] = 16'hFFFF;
        pattern[1] = 16'h1111;
        pattern[2] = 16'h4444;
        pattern[3] = 16'h4444;
        note_num[0] = 8'd42;
        note_num[1] = 8'd36;
        note_num[2] = 8'd50;
        note_num[3] = 8'd38;
        cur_step = 4'd0;
        tick_cnt = 0;
        shown = 3'd1;
        playing = 1'b0;
        reg_step_ticks = 16'd40;
        reg_flash_ticks = 16'd10;
        reg_channel = 4'd0;
        reg_velocity = 7'd127;
    endfunction

    function automatic int unsigned step_len();
        return (reg_step_ticks == 16'd0) ? 1 : int'(reg_step_ticks);
    endfunction

    function automatic logic [15:0] led_now();
        logic [15:0] m;
        int unsigned fl;
        m = pattern[shown];
        fl = (reg_flash_ticks < step_len()) ? int'(reg_flash_ticks) : step_len();
        if (playing && tick_cnt < fl)
            m[cur_step] = ~m[cur_step];
        return m;
    endfunction

    // one word is held back so that the last word of an item can be marked
    function automatic void push_word(logic [7:0] b, logic v);
        if (have_held)
            words_due.push_back(held_word);
        held_word.midi_byte = b;
        held_word.valid     = v;
        held_word.last      = 1'b0;
        held_word.snap.step = cur_step;
        held_word.snap.trk  = shown;
        held_word.snap.led  = led_now();
        held_word.snap.run  = playing;
        have_held = 1'b1;
    endfunction

    function automatic void walk_tracks(logic [3:0] status);
        for (int t = 0; t < TRACK_COUNT; t++) begin
            if (pattern[t][cur_step] && note_num[t] <= 8'd127) begin
                push_word({status, reg_channel}, 1'b1);
                push_word(note_num[t], 1'b1);
                push_word({1'b0, reg_velocity}, 1'b1);
            end
        end
    endfunction

    function automatic void apply_command(t_cmd c, logic [3:0] k, logic [2:0] s,
                                          logic [7:0] v);
        have_held = 1'b0;
        case (c)
            CMD_TICK: begin
                if (playing) begin
                    tick_cnt++;
                    if (tick_cnt >= step_len()) begin
                        walk_tracks(ST_NOTE_OFF);
                        cur_step = cur_step + 4'd1;
                        tick_cnt = 0;
                        walk_tracks(ST_NOTE_ON);
                    end
                end
            end
            CMD_KEY: pattern[shown][k] = ~pattern[shown][k];
            CMD_SEL: shown = s;
            CMD_CLR: begin
                if (playing)
                    walk_tracks(ST_NOTE_OFF);
                for (int t = 0; t < TRACK_COUNT; t++)
                    pattern[t] = 16'h0000;
                shown = 3'd0;
                cur_step = 4'd0;
                tick_cnt = 0;
            end
            CMD_INST: note_num[shown] = v;
            CMD_START: begin
                if (!playing) begin
                    playing = 1'b1;
                    cur_step = 4'd0;
                    tick_cnt = 0;
                    walk_tracks(ST_NOTE_ON);
                end
            end
            CMD_STOP: begin
                if (playing) begin
                    walk_tracks(ST_NOTE_OFF);
                    playing = 1'b0;
                end
            end
            default: ;
        endcase
        if (!have_held)
            push_word(8'd0, 1'b0);
        held_word.last = 1'b1;
        words_due.push_back(held_word);
        have_held = 1'b0;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (words_due.size() == 0) begin
                note_error($sformatf("unexpected word byte=%02h", o_midi_byte));
            end else begin
                want_word = words_due.pop_front();
                words_checked++;
                if (o_byte_valid)
                    notes_checked++;
                if (o_midi_byte !== want_word.midi_byte)
                    note_error($sformatf("midi_byte %02h, want %02h",
                                         o_midi_byte, want_word.midi_byte));
                if (o_byte_valid !== want_word.valid)
                    note_error($sformatf("byte_valid %b, want %b",
                                         o_byte_valid, want_word.valid));
                if (o_last !== want_word.last)
                    note_error($sformatf("last %b, want %b", o_last, want_word.last));
                if (o_step_index !== want_word.snap.step)
                    note_error($sformatf("step_index %0d, want %0d",
                                         o_step_index, want_word.snap.step));
                if (o_shown_track !== want_word.snap.trk)
                    note_error($sformatf("shown_track %0d, want %0d",
                                         o_shown_track, want_word.snap.trk));
                if (o_led_mask !== want_word.snap.led)
                    note_error($sformatf("led_mask %04h, want %04h",
                                         o_led_mask, want_word.snap.led));
                if (o_running !== want_word.snap.run)
                    note_error($sformatf("running %b, want %b",
                                         o_running, want_word.snap.run));
            end
        end
    end

    task automatic idle_for(int n);
        repeat (n) begin
            @(negedge i_clk);
            i_start = 1'b0;
        end
    endtask

    task automatic send_word(t_cmd c, logic [3:0] k, logic [2:0] s, logic [7:0] v);
        if (gaps_on && $urandom_range(3) == 0)
            idle_for($urandom_range(1, 9));
        @(negedge i_clk);
        i_start = 1'b1;
        i_cmd = c;
        i_key_index = k;
        i_track_select = s;
        i_instrument_value = v;
        do @(posedge i_clk); while (o_busy);
        apply_command(c, k, s, v);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_start = 1'b0;
        while (words_due.size() != 0)
            @(posedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_STEP_TICKS:  reg_step_ticks = val;
            CFG_FLASH_TICKS: reg_flash_ticks = val;
            CFG_CHANNEL:     reg_channel = val[3:0];
            CFG_VELOCITY:    reg_velocity = val[6:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [15:0] st, logic [15:0] fl, logic [3:0] ch,
                            logic [6:0] vel);
        wait_drained();
        write_reg(CFG_STEP_TICKS, st);
        write_reg(CFG_FLASH_TICKS, fl);
        write_reg(CFG_CHANNEL, {12'd0, ch});
        write_reg(CFG_VELOCITY, {9'd0, vel});
    endtask

    task automatic test_power_on_defaults();
        send_word(CMD_TICK, 4'd0, 3'd0, 8'd0);
        send_word(CMD_STOP, 4'd0, 3'd0, 8'd0);
        send_word(CMD_NOP, 4'hF, 3'd7, 8'hFF);
        send_word(CMD_START, 4'd0, 3'd0, 8'd0);
        send_word(CMD_START, 4'd0, 3'd0, 8'd0);
        send_word(CMD_TICK, 4'd0, 3'd0, 8'd0);
    endtask

    task automatic test_edit_and_mute();
        send_word(CMD_KEY, 4'd0, 3'd0, 8'd0);
        send_word(CMD_KEY, 4'd15, 3'd0, 8'd0);
        send_word(CMD_SEL, 4'd0, 3'd7, 8'd0);
        send_word(CMD_INST, 4'd0, 3'd0, 8'd255);
        send_word(CMD_SEL, 4'd0, 3'd2, 8'd0);
        send_word(CMD_INST, 4'd0, 3'd0, 8'd128);
        send_word(CMD_SEL, 4'd0, 3'd0, 8'd0);
        // note change while the step's notes are still sounding
        send_word(CMD_INST, 4'd0, 3'd0, 8'd0);
        send_word(CMD_STOP, 4'd0, 3'd0, 8'd0);
        send_word(CMD_CLR, 4'd0, 3'd0, 8'd0);
        send_word(CMD_START, 4'd0, 3'd0, 8'd0);
        send_word(CMD_KEY, 4'd0, 3'd0, 8'd0);
        send_word(CMD_CLR, 4'd0, 3'd0, 8'd0);
        send_word(CMD_INST, 4'd0, 3'd0, 8'd127);
    endtask

    task automatic test_register_extremes();
        set_regs(16'd1, 16'd0, 4'd15, 7'd0);
        send_word(CMD_KEY, 4'd1, 3'd0, 8'd0);
        send_word(CMD_TICK, 4'd0, 3'd0, 8'd0);
        send_word(CMD_TICK, 4'd0, 3'd0, 8'd0);
        // zero step length acts as one tick, flash is capped at the step
        set_regs(16'd0, 16'hFFFF, 4'd0, 7'd127);
        send_word(CMD_TICK, 4'd0, 3'd0, 8'd0);
        send_word(CMD_TICK, 4'd0, 3'd0, 8'd0);
        set_regs(16'hFFFF, 16'd3, 4'd9, 7'd64);
        send_word(CMD_TICK, 4'd0, 3'd0, 8'd0);
        send_word(CMD_STOP, 4'd0, 3'd0, 8'd0);
    endtask

    task automatic random_command();
        int pick;
        t_cmd c;
        logic [7:0] v;
        pick = $urandom_range(99);
        if (!playing && $urandom_range(1) == 0)
            c = CMD_START;
        else if (pick < 62) c = CMD_TICK;
        else if (pick < 76) c = CMD_KEY;
        else if (pick < 82) c = CMD_SEL;
        else if (pick < 87) c = CMD_INST;
        else if (pick < 90) c = CMD_START;
        else if (pick < 94) c = CMD_STOP;
        else if (pick < 96) c = CMD_CLR;
        else c = CMD_NOP;
        v = ($urandom_range(4) == 0) ? 8'($urandom_range(128, 255))
                                     : 8'($urandom_range(0, 127));
        send_word(c, 4'($urandom), 3'($urandom), v);
    endtask

    task automatic random_phase(int n, logic [15:0] st, logic [15:0] fl, logic [3:0] ch,
                                logic [6:0] vel, bit hold_mid);
        set_regs(st, fl, ch, vel);
        for (int i = 0; i < n; i++) begin
            if (hold_mid && i == n / 2)
                wait_drained();
            random_command();
        end
    endtask

    task automatic test_random_play();
        random_phase(100, 16'd2, 16'd1, 4'($urandom), 7'($urandom), 1'b0);
        random_phase(100, 16'd1, 16'd0, 4'd15, 7'd127, 1'b1);
        random_phase(100, 16'd3, 16'd3, 4'd0, 7'd0, 1'b0);
        random_phase(100, 16'($urandom_range(1, 5)), 16'($urandom_range(0, 6)),
                     4'($urandom), 7'($urandom), 1'b0);
        gaps_on = 1'b0;
        random_phase(100, 16'd2, 16'hFFFF, 4'($urandom), 7'($urandom), 1'b0);
    endtask

    initial begin
        errors = 0;
        items_sent = 0;
        words_checked = 0;
        notes_checked = 0;
        cycles = 0;
        gaps_on = 1'b1;
        have_held = 1'b0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cmd = CMD_NOP;
        i_key_index = 4'd0;
        i_track_select = 3'd0;
        i_instrument_value = 8'd0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_STEP_TICKS;
        i_cfg_data = 16'd0;
        reset_mirror();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_power_on_defaults();
        test_edit_and_mute();
        test_register_extremes();
        test_random_play();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d command words; checked %0d result words, %0d of them MIDI bytes.",
                 items_sent, words_checked, notes_checked);
        $display("Covered all commands, muting, clear while running and register extremes.");
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/dssm_pkg.sv
rtl/drum_step_sequencer_midi_top.sv
rtl/dssm_chk.sv
bench/tb_top.sv
